>>> rtl/sdmd_pkg.sv
// Shared types, widths and register codes of the sigma-delta motion detector.
`default_nettype none

package sdmd_pkg;

	// Store depth, the address width that follows from it, and the field widths
	localparam int unsigned MAX_PIXELS = 131072;
	localparam int unsigned ADDR_W     = $clog2(MAX_PIXELS);
	localparam int unsigned FRAME_W    = 18;
	localparam int unsigned GAIN_W     = 3;
	localparam int unsigned PIX_W      = 8;
	localparam int unsigned VAR_W      = 8;
	localparam int unsigned TGT_W      = GAIN_W + PIX_W;

	// APB register window
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	// Largest frame the store can hold
	localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_PIXELS);

	// Reset values of the configuration registers
	localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(76800);
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(3);
	localparam logic [VAR_W-1:0]   VMIN_RESET  = VAR_W'(1);
	localparam logic [VAR_W-1:0]   VMAX_RESET  = VAR_W'(254);

	// Register index, taken from paddr word bits
	typedef enum logic [1:0] {
		REG_FRAME_PIXELS   = 2'd0,
		REG_DEVIATION_GAIN = 2'd1,
		REG_VARIANCE_MIN   = 2'd2,
		REG_VARIANCE_MAX   = 2'd3
	} reg_index_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [FRAME_W-1:0] frame_pixels;
		logic [GAIN_W-1:0]  deviation_gain;
		logic [VAR_W-1:0]   variance_min;
		logic [VAR_W-1:0]   variance_max;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/sigma_delta_motion_detect_unit.sv
// Sigma-delta background subtraction: top level with pipeline and pixel stores.
// The unit takes one grey pixel word per clock in raster order while the result side does not
// stall, and returns one result word per pixel, in the order the pixels were accepted.
// A pixel counter that wraps at frame_pixels (zero taken as one, capped at 131072) addresses
// a background store and a variance store of 131072 entries each; both are single memories
// with one write and one registered read per cycle. Stage 1 steps the background, stage 2
// multiplies the difference by the gain, stage 3 steps and clamps the variance and flags
// motion, and the output register holds the result word. The background is written as a pixel
// leaves stage 1 and the variance as it leaves stage 3; a single-entry bypass on each store
// covers the write that lands on the same edge as the next read, so the rate stays one pixel
// per clock even for a one-pixel frame. The stores have no reset and no clearing pass: run one
// frame with func set to initialize before any update frame.
`default_nettype none

module sigma_delta_motion_detect_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel channel
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          func,
	input  wire logic [sdmd_pkg::PIX_W-1:0]    pixel,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               motion,
	output logic      [sdmd_pkg::PIX_W-1:0]    difference,
	output logic      [sdmd_pkg::PIX_W-1:0]    background,
	output logic                               frame_end,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sdmd_pkg::APB_AW-1:0]   paddr,
	input  wire logic [sdmd_pkg::APB_DW-1:0]   pwdata,
	output logic      [sdmd_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);
	import sdmd_pkg::*;

	cfg_t cfg;

	sdmd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stores
	logic [PIX_W-1:0] bg_mem  [MAX_PIXELS];
	logic [VAR_W-1:0] var_mem [MAX_PIXELS];

	// Pixel counter
	logic [ADDR_W-1:0]  pixel_address_q;
	logic [FRAME_W-1:0] frame_m1;
	logic               last_s0;
	logic               accept;

	// Stage valids and flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic ready_1, ready_2, ready_3, ready_4;

	// Stage 1
	logic              func_s1, last_s1, fwd_bg_s1;
	logic [PIX_W-1:0]  pixel_s1, bg_rd_s1, bg_fwd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  bg_old_s1, bg_new_s1, diff_new_s1;

	// Stage 2
	logic              func_s2, last_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PIX_W-1:0]  bg_s2, diff_s2;
	logic [TGT_W-1:0]  target_new_s2;

	// Stage 3
	logic              func_s3, last_s3, fwd_var_s3;
	logic [ADDR_W-1:0] addr_s3;
	logic [PIX_W-1:0]  bg_s3, diff_s3;
	logic [TGT_W-1:0]  target_s3;
	logic [VAR_W-1:0]  var_rd_s3, var_fwd_s3;
	logic [VAR_W-1:0]  var_old_s3, var_new_s3;
	logic [VAR_W:0]    var_step_s3;
	logic              motion_new_s3;

	// Output stage
	logic              motion_s4, last_s4;
	logic [PIX_W-1:0]  bg_s4, diff_s4;

	// Flow control: a stage moves when it is empty or the next one moves
	assign ready_4    = !v_s4 || !result_stall;
	assign ready_3    = !v_s3 || ready_4;
	assign ready_2    = !v_s2 || ready_3;
	assign ready_1    = !v_s1 || ready_2;
	assign item_stall = !ready_1;
	assign accept     = item_valid && ready_1;

	// Last pixel of the frame, with frame size zero as one and capped at the store depth
	always_comb begin
		if (cfg.frame_pixels == '0) begin
			frame_m1 = '0;
		end else if (cfg.frame_pixels > FRAME_MAX) begin
			frame_m1 = FRAME_MAX - FRAME_W'(1);
		end else begin
			frame_m1 = cfg.frame_pixels - FRAME_W'(1);
		end
	end
	assign last_s0 = FRAME_W'(pixel_address_q) >= frame_m1;

	// Advance or wrap the pixel counter per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_address_q <= '0;
		end else if (accept) begin
			pixel_address_q <= last_s0 ? '0 : pixel_address_q + ADDR_W'(1);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_1) v_s1 <= item_valid;
			if (ready_2) v_s2 <= v_s1;
			if (ready_3) v_s3 <= v_s2;
			if (ready_4) v_s4 <= v_s3;
		end
	end

	// Background store: read on accept, write as a word leaves stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			bg_rd_s1 <= bg_mem[pixel_address_q];
		end
		if (v_s1 && ready_2) begin
			bg_mem[addr_s1] <= bg_new_s1;
		end
	end

	// Variance store: read as a word enters stage 3, write as it leaves stage 3
	always_ff @(posedge clk) begin
		if (v_s2 && ready_3) begin
			var_rd_s3 <= var_mem[addr_s2];
		end
		if (v_s3 && ready_4) begin
			var_mem[addr_s3] <= var_new_s3;
		end
	end

	// Stage 1 capture, with bypass of the background written on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			pixel_s1  <= pixel;
			addr_s1   <= pixel_address_q;
			last_s1   <= last_s0;
			fwd_bg_s1 <= v_s1 && (addr_s1 == pixel_address_q);
			bg_fwd_s1 <= bg_new_s1;
		end
	end

	// Load or step the background one count toward the pixel, take the absolute difference
	always_comb begin
		bg_old_s1 = fwd_bg_s1 ? bg_fwd_s1 : bg_rd_s1;
		if (func_s1) begin
			bg_new_s1 = pixel_s1;
		end else if (bg_old_s1 < pixel_s1) begin
			bg_new_s1 = bg_old_s1 + PIX_W'(1);
		end else if (bg_old_s1 > pixel_s1) begin
			bg_new_s1 = bg_old_s1 - PIX_W'(1);
		end else begin
			bg_new_s1 = bg_old_s1;
		end
		diff_new_s1 = (bg_new_s1 > pixel_s1) ? bg_new_s1 - pixel_s1 : pixel_s1 - bg_new_s1;
	end

	// Stage 2 capture
	always_ff @(posedge clk) begin
		if (v_s1 && ready_2) begin
			func_s2 <= func_s1;
			addr_s2 <= addr_s1;
			last_s2 <= last_s1;
			bg_s2   <= bg_new_s1;
			diff_s2 <= diff_new_s1;
		end
	end

	// Scale the difference by the gain
	assign target_new_s2 = TGT_W'(cfg.deviation_gain) * TGT_W'(diff_s2);

	// Stage 3 capture, with bypass of the variance written on the same edge
	always_ff @(posedge clk) begin
		if (v_s2 && ready_3) begin
			func_s3    <= func_s2;
			addr_s3    <= addr_s2;
			last_s3    <= last_s2;
			bg_s3      <= bg_s2;
			diff_s3    <= diff_s2;
			target_s3  <= target_new_s2;
			fwd_var_s3 <= v_s3 && (addr_s3 == addr_s2);
			var_fwd_s3 <= var_new_s3;
		end
	end

	// Step the variance toward the target or load the minimum, clamp, and flag motion
	always_comb begin
		var_old_s3 = fwd_var_s3 ? var_fwd_s3 : var_rd_s3;
		if (TGT_W'(var_old_s3) < target_s3) begin
			var_step_s3 = (VAR_W + 1)'(var_old_s3) + (VAR_W + 1)'(1);
		end else if (TGT_W'(var_old_s3) > target_s3) begin
			var_step_s3 = (VAR_W + 1)'(var_old_s3) - (VAR_W + 1)'(1);
		end else begin
			var_step_s3 = (VAR_W + 1)'(var_old_s3);
		end
		if (func_s3) begin
			var_new_s3 = cfg.variance_min;
		end else if (var_step_s3 > (VAR_W + 1)'(cfg.variance_max)) begin
			var_new_s3 = cfg.variance_max;
		end else begin
			var_new_s3 = var_step_s3[VAR_W-1:0];
		end
		if (!func_s3 && (var_new_s3 < cfg.variance_min)) begin
			var_new_s3 = cfg.variance_min;
		end
		motion_new_s3 = !func_s3 && (diff_s3 >= var_new_s3);
	end

	// Output register: hold while the result side stalls
	always_ff @(posedge clk) begin
		if (v_s3 && ready_4) begin
			motion_s4 <= motion_new_s3;
			diff_s4   <= diff_s3;
			bg_s4     <= bg_s3;
			last_s4   <= last_s3;
		end
	end

	assign result_valid = v_s4;
	assign motion       = motion_s4;
	assign difference   = diff_s4;
	assign background   = bg_s4;
	assign frame_end    = last_s4;

	// Counter wraps to zero after the last pixel of a frame
	a_addr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_s0) |=> (pixel_address_q == '0))
		else $error("pixel counter did not wrap after frame end");

	// Written variance stays inside an ordered clamp range
	a_var_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ready_4 && (cfg.variance_min <= cfg.variance_max)) |->
		((var_new_s3 >= cfg.variance_min) && (var_new_s3 <= cfg.variance_max)))
		else $error("variance written outside clamp range");

	// A blocked stage 1 word stays in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ready_2) |=> (v_s1 && $stable(addr_s1) && $stable(pixel_s1)))
		else $error("stage 1 word lost while blocked");

	// Background moves at most one count per update
	a_bg_step: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !func_s1) |->
		((bg_new_s1 == bg_old_s1) || (bg_new_s1 == bg_old_s1 + PIX_W'(1)) ||
		 (bg_new_s1 == bg_old_s1 - PIX_W'(1))))
		else $error("background stepped by more than one count");

endmodule

`default_nettype wire

>>> rtl/sdmd_apb_regs.sv
// APB configuration registers of the sigma-delta motion detector.
`default_nettype none

module sdmd_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sdmd_pkg::APB_AW-1:0]  paddr,
	input  wire logic [sdmd_pkg::APB_DW-1:0]  pwdata,
	output logic      [sdmd_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	output sdmd_pkg::cfg_t                    cfg
);
	import sdmd_pkg::*;

	cfg_t       cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_pixels   <= FRAME_RESET;
			cfg_q.deviation_gain <= GAIN_RESET;
			cfg_q.variance_min   <= VMIN_RESET;
			cfg_q.variance_max   <= VMAX_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_FRAME_PIXELS:   cfg_q.frame_pixels   <= pwdata[FRAME_W-1:0];
				REG_DEVIATION_GAIN: cfg_q.deviation_gain <= pwdata[GAIN_W-1:0];
				REG_VARIANCE_MIN:   cfg_q.variance_min   <= pwdata[VAR_W-1:0];
				REG_VARIANCE_MAX:   cfg_q.variance_max   <= pwdata[VAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero extended
	always_comb begin
		case (idx)
			REG_FRAME_PIXELS:   prdata = APB_DW'(cfg_q.frame_pixels);
			REG_DEVIATION_GAIN: prdata = APB_DW'(cfg_q.deviation_gain);
			REG_VARIANCE_MIN:   prdata = APB_DW'(cfg_q.variance_min);
			REG_VARIANCE_MAX:   prdata = APB_DW'(cfg_q.variance_max);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire
